### design/ddo_pkg.sv
`timescale 1ns / 1ps

package ddo_pkg;

	// One odometry request: wheel speeds in signed Q8.8 m/s and the pose clear flag.
	typedef struct packed {
		logic signed [15:0] vel_left;
		logic signed [15:0] vel_right;
		logic               clear_pose;
	} ddo_in_t;

	// One pose update: Q16.16 position, binary-angle heading and the clip flag.
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
		logic               saturated;
	} ddo_out_t;

	// Sequencer states: multiply steps, CORDIC setup, rotations and pose update.
	typedef enum logic [3:0] {
		S_IDLE,
		S_M_SP,
		S_M_UL,
		S_M_UH,
		S_M_DI,
		S_M_DP,
		S_M_RL,
		S_M_RH,
		S_M_RA,
		S_PREP,
		S_ROT,
		S_FIN
	} ddo_state_t;

	// Configuration register indexes.
	localparam int unsigned REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_PERIOD    = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_INV_TRACK = 1'b1;

	localparam logic [15:0] PERIOD_RESET    = 16'd6554;
	localparam logic [15:0] INV_TRACK_RESET = 16'd853;

	// Reciprocal CORDIC gain in Q1.30, split into two 15-bit halves for the multiplier.
	localparam logic [29:0] INV_GAIN    = 30'd652032874;
	localparam logic [14:0] INV_GAIN_LO = INV_GAIN[14:0];
	localparam logic [14:0] INV_GAIN_HI = INV_GAIN[29:15];

	// Radians to binary angle (32768/pi) in Q16.16, split the same way.
	localparam logic [29:0] RAD_TO_BAM    = 30'd683565276;
	localparam logic [14:0] RAD_TO_BAM_LO = RAD_TO_BAM[14:0];
	localparam logic [14:0] RAD_TO_BAM_HI = RAD_TO_BAM[29:15];

	// Angle constants with a full turn at 2^32.
	localparam logic signed [32:0] ANG_QUARTER = 33'sh040000000;
	localparam logic signed [32:0] ANG_HALF    = 33'sh080000000;

	// Arctangent of 2^-i in the same angle units.
	localparam int unsigned ATAN_ENTRIES = 24;
	localparam int unsigned ATAN_IDX_W   = 5;
	localparam logic [29:0] ATAN_TAB [ATAN_ENTRIES] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10680862,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81
	};

endpackage

### design/differential_drive_odometry.sv
// The datapath makes seven passes through one shared 33x16 multiplier and one CORDIC
// rotation per cycle in a single shared rotator. A new request is taken only in the idle
// state, once the previous result has entered the output register; a clear request skips
// the multiply and rotation states.
// Reset (arst_n low, asynchronous) zeroes the pose, restores the register defaults,
// and empties the output register.
`timescale 1ns / 1ps

module differential_drive_odometry #(
	parameter int unsigned CORDIC_STAGES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ddo_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                     cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ddo_pkg::ddo_in_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ddo_pkg::ddo_out_t               out_data
);
	import ddo_pkg::*;

	localparam int unsigned IW = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;
	localparam logic [IW-1:0] LAST_STAGE = IW'(CORDIC_STAGES - 1);
	localparam int unsigned XW = 36;

	ddo_state_t state_q, state_d;

	logic [15:0] period_q;
	logic [15:0] inv_track_q;

	logic signed [31:0] pose_x_q;
	logic signed [31:0] pose_y_q;
	logic [15:0]        pose_h_q;

	logic               out_valid_q;
	ddo_out_t           out_q;

	logic               clr_q;
	logic signed [16:0] sum_q;
	logic signed [16:0] diff_q;
	logic signed [48:0] prod_q;
	logic signed [32:0] t_q;
	logic signed [63:0] acc_q;
	logic signed [33:0] u_q;

	logic signed [XW-1:0] x_q, y_q;
	logic signed [32:0]   z_q;
	logic [IW-1:0]        i_q;

	// Control outputs of the sequencer.
	logic               accept;
	logic               fin_fire;
	logic signed [32:0] mul_a;
	logic [15:0]        mul_b;

	// Shared multiplier: signed 33 bits by unsigned 16 bits.
	logic signed [49:0] mul_full;
	logic signed [48:0] mul_p;
	assign mul_full = mul_a * $signed({1'b0, mul_b});
	assign mul_p    = mul_full[48:0];

	logic signed [63:0] prod_ext;
	assign prod_ext = {{15{prod_q[48]}}, prod_q};

	// Midpoint heading for the rotation and its fold into the right half plane.
	logic [31:0]          mid;
	logic signed [32:0]   z_mid;
	logic signed [XW-1:0] u_ext;
	assign mid   = {pose_h_q, 16'h0000} + acc_q[48:17];
	assign z_mid = $signed({mid[31], mid});
	assign u_ext = {{(XW-34){u_q[33]}}, u_q};

	// One CORDIC rotation step.
	logic signed [XW-1:0] xs, ys;
	logic signed [32:0]   atan_v;
	assign xs     = x_q >>> i_q;
	assign ys     = y_q >>> i_q;
	assign atan_v = $signed({3'b000, ATAN_TAB[ATAN_IDX_W'(i_q)]});

	// Position update with clipping to the signed 32-bit range.
	logic signed [XW-1:0] dx_full, dy_full;
	logic signed [32:0]   sum_x, sum_y;
	logic                 ovf_x, ovf_y;
	logic signed [31:0]   new_x, new_y;
	logic [15:0]          new_h;
	assign dx_full = x_q >>> 9;
	assign dy_full = y_q >>> 9;
	assign sum_x   = {pose_x_q[31], pose_x_q} + dx_full[32:0];
	assign sum_y   = {pose_y_q[31], pose_y_q} + dy_full[32:0];
	assign ovf_x   = sum_x[32] != sum_x[31];
	assign ovf_y   = sum_y[32] != sum_y[31];
	assign new_x   = ovf_x ? (sum_x[32] ? 32'sh80000000 : 32'sh7fffffff) : sum_x[31:0];
	assign new_y   = ovf_y ? (sum_y[32] ? 32'sh80000000 : 32'sh7fffffff) : sum_y[31:0];
	assign new_h   = pose_h_q + acc_q[47:32];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = in_data.clear_pose ? S_FIN : S_M_SP;
				end
			end
			S_M_SP: state_d = S_M_UL;
			S_M_UL: state_d = S_M_UH;
			S_M_UH: state_d = S_M_DI;
			S_M_DI: state_d = S_M_DP;
			S_M_DP: state_d = S_M_RL;
			S_M_RL: state_d = S_M_RH;
			S_M_RH: state_d = S_M_RA;
			S_M_RA: state_d = S_PREP;
			S_PREP: state_d = S_ROT;
			S_ROT: begin
				if (i_q == LAST_STAGE) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: handshake and multiplier operand selection.
	always_comb begin
		in_ready = 1'b0;
		fin_fire = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_M_SP: begin
				mul_a = {{16{sum_q[16]}}, sum_q};
				mul_b = period_q;
			end
			S_M_UL: begin
				mul_a = prod_q[32:0];
				mul_b = {1'b0, INV_GAIN_LO};
			end
			S_M_UH: begin
				mul_a = t_q;
				mul_b = {1'b0, INV_GAIN_HI};
			end
			S_M_DI: begin
				mul_a = {{16{diff_q[16]}}, diff_q};
				mul_b = inv_track_q;
			end
			S_M_DP: begin
				mul_a = prod_q[32:0];
				mul_b = period_q;
			end
			S_M_RL: begin
				mul_a = prod_q[48:16];
				mul_b = {1'b0, RAD_TO_BAM_LO};
			end
			S_M_RH: begin
				mul_a = t_q;
				mul_b = {1'b0, RAD_TO_BAM_HI};
			end
			S_FIN: fin_fire = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Control state, configuration registers and the pose.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			out_valid_q <= 1'b0;
			period_q    <= PERIOD_RESET;
			inv_track_q <= INV_TRACK_RESET;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			pose_h_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_PREP) begin
				i_q <= '0;
			end else if (state_q == S_ROT) begin
				i_q <= i_q + 1'b1;
			end
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PERIOD:    period_q    <= cfg_data;
					REG_INV_TRACK: inv_track_q <= cfg_data;
					default: ;
				endcase
			end
			if (fin_fire) begin
				if (clr_q) begin
					pose_x_q <= '0;
					pose_y_q <= '0;
					pose_h_q <= '0;
				end else begin
					pose_x_q <= new_x;
					pose_y_q <= new_y;
					pose_h_q <= new_h;
				end
			end
		end
	end

	// Datapath registers: operands, products, accumulator and CORDIC vector.
	always_ff @(posedge clk) begin
		if (accept) begin
			clr_q  <= in_data.clear_pose;
			sum_q  <= 17'(in_data.vel_left) + 17'(in_data.vel_right);
			diff_q <= 17'(in_data.vel_right) - 17'(in_data.vel_left);
		end
		case (state_q)
			S_M_SP: prod_q <= mul_p;
			S_M_UL: begin
				t_q    <= prod_q[32:0];
				prod_q <= mul_p;
			end
			S_M_UH: begin
				acc_q  <= prod_ext;
				prod_q <= mul_p;
			end
			S_M_DI: begin
				acc_q  <= acc_q + (prod_ext <<< 15);
				prod_q <= mul_p;
			end
			S_M_DP: begin
				u_q    <= acc_q[63:30];
				prod_q <= mul_p;
			end
			S_M_RL: begin
				t_q    <= prod_q[48:16];
				prod_q <= mul_p;
			end
			S_M_RH: begin
				acc_q  <= prod_ext;
				prod_q <= mul_p;
			end
			S_M_RA: acc_q <= acc_q + (prod_ext <<< 15);
			S_PREP: begin
				y_q <= '0;
				if (z_mid > ANG_QUARTER) begin
					x_q <= -u_ext;
					z_q <= z_mid - ANG_HALF;
				end else if (z_mid < -ANG_QUARTER) begin
					x_q <= -u_ext;
					z_q <= z_mid + ANG_HALF;
				end else begin
					x_q <= u_ext;
					z_q <= z_mid;
				end
			end
			S_ROT: begin
				if (!z_q[32]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_v;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_v;
				end
			end
			default: ;
		endcase
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (fin_fire) begin
			if (clr_q) begin
				out_q <= '0;
			end else begin
				out_q.pos_x     <= new_x;
				out_q.pos_y     <= new_y;
				out_q.heading   <= $signed(new_h);
				out_q.saturated <= ovf_x || ovf_y;
			end
		end
	end

	// A finished result never overwrites one that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire |-> (!out_valid_q || out_ready))
		else $error("result issued while output register was occupied");

	// Each finished result shows up on the output in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire |=> (out_valid && state_q == S_IDLE))
		else $error("finished result not presented");

	// The rotator always starts from the first stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PREP) |=> (state_q == S_ROT && i_q == '0))
		else $error("rotation did not start at stage zero");

	// A motion request always enters the multiply sequence.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_data.clear_pose) |=> (state_q == S_M_SP))
		else $error("motion request skipped the multiply sequence");

	// The heading only changes when a result is issued.
	assert property (@(posedge clk) disable iff (!arst_n)
		!fin_fire |=> $stable(pose_h_q))
		else $error("heading changed outside of a pose update");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ddo_pkg::*;

	localparam int unsigned STAGES      = 16;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned DRAIN       = 40;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam longint      POS_MAX     = 64'sd2147483647;
	localparam longint      POS_MIN     = -(64'sd2147483648);

	// Traffic shapes for the request and pose channels.
	typedef enum {
		PACE_FULL,
		PACE_SEND_IDLE,
		PACE_RECV_STALL,
		PACE_BOTH,
		PACE_HOLD
	} pace_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = REG_PERIOD;
	logic [15:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	ddo_in_t              in_data = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	ddo_out_t             out_data;

	// Predictor copy of the registers and the pose.
	logic [15:0] cfg_period = PERIOD_RESET;
	logic [15:0] cfg_inv_track = INV_TRACK_RESET;
	longint      pose_x = 0;
	longint      pose_y = 0;
	logic [15:0] pose_hd = '0;

	ddo_in_t  request_backlog[$];
	ddo_out_t pose_expected[$];
	pace_t    pace = PACE_FULL;

	int unsigned n_errors = 0;
	int unsigned n_requests = 0;
	int unsigned n_updates = 0;
	int unsigned n_clears = 0;
	int unsigned n_clipped = 0;
	int unsigned n_settings = 0;
	int unsigned stall_left = 0;
	bit          hold_done = 1'b0;
	int unsigned quiet = 0;

	differential_drive_odometry #(
		.CORDIC_STAGES(STAGES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Clip a position to the signed 32-bit range and flag it.
	function automatic longint saturate32(longint v, inout bit hit);
		if (v > POS_MAX) begin
			hit = 1'b1;
			return POS_MAX;
		end
		if (v < POS_MIN) begin
			hit = 1'b1;
			return POS_MIN;
		end
		return v;
	endfunction

	// Advance the predicted pose by one odometry request and return the update.
	function automatic ddo_out_t advance_pose(ddo_in_t req);
		longint      vl, vr, dist_q, turn_q, turn_bam, ang, z, cx, cy, cxs, cys;
		logic [31:0] mid_ang;
		bit          clipped;
		ddo_out_t    res;
		clipped = 1'b0;
		if (req.clear_pose) begin
			pose_x = 0;
			pose_y = 0;
			pose_hd = '0;
		end else begin
			vl = req.vel_left;
			vr = req.vel_right;
			// Distance step pre-scaled by the reciprocal CORDIC gain.
			dist_q = ((vl + vr) * longint'(cfg_period) * longint'(INV_GAIN)) >>> 30;
			// Heading step in Q16.16 radians, then in 2^-48 turns.
			turn_q = ((vr - vl) * longint'(cfg_inv_track) * longint'(cfg_period)) >>> 16;
			turn_bam = turn_q * longint'(RAD_TO_BAM);
			ang = turn_bam >>> 17;
			mid_ang = {pose_hd, 16'h0000} + ang[31:0];
			z = $signed(mid_ang);
			cx = dist_q;
			cy = 0;
			// Fold the midpoint angle into the right half plane.
			if (z > longint'(ANG_QUARTER)) begin
				cx = -cx;
				z = z - longint'(ANG_HALF);
			end else if (z < -longint'(ANG_QUARTER)) begin
				cx = -cx;
				z = z + longint'(ANG_HALF);
			end
			for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
				cxs = cx >>> i;
				cys = cy >>> i;
				if (z >= 0) begin
					cx = cx - cys;
					cy = cy + cxs;
					z = z - longint'(ATAN_TAB[i]);
				end else begin
					cx = cx + cys;
					cy = cy - cxs;
					z = z + longint'(ATAN_TAB[i]);
				end
			end
			pose_x = saturate32(pose_x + (cx >>> 9), clipped);
			pose_y = saturate32(pose_y + (cy >>> 9), clipped);
			pose_hd = pose_hd + turn_bam[47:32];
		end
		res.pos_x = pose_x[31:0];
		res.pos_y = pose_y[31:0];
		res.heading = pose_hd;
		res.saturated = clipped;
		return res;
	endfunction

	function automatic logic [15:0] extreme_speed();
		int vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
		return 16'(vals[$urandom_range(6)]);
	endfunction

	// Mix of full-range, extreme and plausible wheel speeds, with a few clears.
	function automatic ddo_in_t random_request();
		ddo_in_t     req;
		int unsigned pick;
		int          base;
		pick = $urandom_range(99);
		base = int'($urandom_range(1024)) - 512;
		req.clear_pose = ($urandom_range(99) < 4);
		if (pick < 30) begin
			req.vel_left = 16'($urandom);
			req.vel_right = 16'($urandom);
		end else if (pick < 45) begin
			req.vel_left = extreme_speed();
			req.vel_right = extreme_speed();
		end else begin
			req.vel_left = 16'(base + int'($urandom_range(64)) - 32);
			req.vel_right = 16'(base + int'($urandom_range(64)) - 32);
		end
		return req;
	endfunction

	task automatic queue_request(logic [15:0] vl, logic [15:0] vr, logic clr);
		ddo_in_t req;
		req.vel_left = vl;
		req.vel_right = vr;
		req.clear_pose = clr;
		request_backlog.push_back(req);
	endtask

	task automatic queue_random(int unsigned count);
		repeat (count) request_backlog.push_back(random_request());
	endtask

	// Clear, turn a little, then drive straight at full speed into the position limit.
	task automatic queue_runaway(bit reverse);
		logic [15:0] spd;
		spd = reverse ? 16'h8000 : 16'h7fff;
		queue_request('0, '0, 1'b1);
		repeat (3) queue_request(16'($urandom), 16'($urandom), 1'b0);
		repeat (200) queue_request(spd, spd, 1'b0);
	endtask

	// Wait until every request is sent and every update has come back.
	task automatic wait_idle();
		do @(negedge clk);
		while (request_backlog.size() != 0 || in_valid || pose_expected.size() != 0);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_settings(logic [15:0] per, logic [15:0] inv_w);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_PERIOD;
		cfg_data <= per;
		@(posedge clk);
		cfg_index <= REG_INV_TRACK;
		cfg_data <= inv_w;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_period = per;
		cfg_inv_track = inv_w;
		n_settings++;
		@(negedge clk);
	endtask

	task automatic check_field(string field, longint want, longint got);
		if (want != got) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// Request driver: keeps valid and payload steady until the request is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				pose_expected.push_back(advance_pose(in_data));
				n_requests++;
				if (in_data.clear_pose)
					n_clears++;
			end
			if (!in_valid || in_ready) begin
				if (request_backlog.size() != 0 &&
				    !((pace == PACE_SEND_IDLE && $urandom_range(99) < 63) ||
				      (pace == PACE_BOTH && $urandom_range(99) < 19))) begin
					in_data <= request_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Pose monitor: checks each update and paces out_ready.
	always @(posedge clk) begin
		ddo_out_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pose_expected.size() == 0) begin
					n_errors++;
					$display("%0t: pose update with nothing expected, actual %p", $time, out_data);
				end else begin
					want = pose_expected.pop_front();
					check_field("pos_x", want.pos_x, out_data.pos_x);
					check_field("pos_y", want.pos_y, out_data.pos_y);
					check_field("heading", want.heading, out_data.heading);
					check_field("saturated", want.saturated, out_data.saturated);
					n_updates++;
					if (want.saturated)
						n_clipped++;
				end
			end
			// A single long hold-off lets the block back up into its input.
			if (pace == PACE_HOLD && !hold_done) begin
				stall_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (pace == PACE_RECV_STALL) begin
				out_ready <= ($urandom_range(99) >= 63);
			end else if (pace == PACE_BOTH) begin
				out_ready <= ($urandom_range(99) >= 19);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no handshake on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, quiet);
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed requests at the reset settings.
		pace = PACE_FULL;
		queue_request(16'h7fff, 16'h8000, 1'b1);
		queue_request(16'h0000, 16'h0000, 1'b0);
		queue_request(16'h7fff, 16'h7fff, 1'b0);
		queue_request(16'h8000, 16'h8000, 1'b0);
		queue_request(16'h7fff, 16'h8000, 1'b0);
		queue_request(16'h8000, 16'h7fff, 1'b0);
		queue_request(16'h0001, 16'h0000, 1'b0);
		queue_request(16'h0000, 16'h0001, 1'b0);
		queue_request(16'hffff, 16'h0000, 1'b0);
		repeat (6) queue_request(16'hff00, 16'h0100, 1'b0);
		queue_request(16'h0100, 16'h0100, 1'b0);
		queue_request(16'h8000, 16'h7fff, 1'b1);
		repeat (4) queue_request(16'h0200, 16'hfe00, 1'b0);
		queue_request(16'hffff, 16'hffff, 1'b0);

		// Largest registers: full-speed runs into the position limits.
		write_settings(16'hffff, 16'hffff);
		queue_runaway(1'b0);
		queue_runaway(1'b1);
		queue_random(100);

		// Smallest registers with an idle sender.
		write_settings(16'h0001, 16'h0001);
		pace = PACE_SEND_IDLE;
		queue_random(250);

		write_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
		pace = PACE_RECV_STALL;
		queue_random(250);

		write_settings(PERIOD_RESET, INV_TRACK_RESET);
		pace = PACE_BOTH;
		queue_random(250);

		// Backpressure: the receiver holds off while requests keep coming.
		write_settings(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
		pace = PACE_HOLD;
		queue_random(200);

		write_settings(16'hffff, INV_TRACK_RESET);
		pace = PACE_BOTH;
		queue_runaway(1'($urandom_range(1)));
		queue_random(100);

		// Zero registers give no motion and no turn.
		write_settings(16'h0000, 16'h0000);
		pace = PACE_FULL;
		queue_random(30);

		wait_idle();
		$display("Checked %0d pose updates from %0d requests (%0d clears, %0d clipped).",
		         n_updates, n_requests, n_clears, n_clipped);
		$display("Register settings: %0d beyond reset; pacing covered idle, stall and hold-off.",
		         n_settings);
		if (n_errors == 0 && pose_expected.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
